// ===== src/agme_pkg.sv =====
// Shared constants, types and helpers of the anisotropic GGX evaluator.
package agme_pkg;

   // Roughness registers: Q1.14, reset to 1.0; read as at least two LSBs.
   localparam int ALPHA_W = 15;
   localparam logic [14:0] ALPHA_RESET = 15'd16384;
   localparam logic [14:0] ALPHA_MIN = 15'd2;

   // Register indexes of the write port.
   localparam logic REG_ALPHA_U = 1'b0;
   localparam logic REG_ALPHA_V = 1'b1;

   // Field widths.
   localparam int DOT_W = 16;
   localparam int COS_W = 16;
   localparam int TAN_W = 32;
   localparam int VALUE_W = 40;
   localparam int REQ_DATA_W = 192;

   // One in Q1.15 for the squared azimuth cosines.
   localparam logic [15:0] COS_ONE = 16'd32768;

   // floor(2^32 / pi).
   localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

   // Steps of the iterative units.
   localparam int DIV_D_STEPS = 43;
   localparam int SQRT_STEPS = 26;
   localparam int DIV_G_STEPS = 17;

   // Register layers from the input register to the result of either path.
   localparam int LAT = 54;
   localparam int G_CORE_LAT = 49;

   // Roughness terms derived from the registers, shared by both paths.
   typedef struct packed {
      logic [29:0] a2;
      logic [29:0] b2;
      logic [59:0] a2b2;
      logic [89:0] pp3;
   } agme_alpha_type;

   // A roughness below two LSBs acts as two LSBs.
   function automatic logic [14:0] alpha_eff(input logic [14:0] r);
      alpha_eff = (r < ALPHA_MIN) ? ALPHA_MIN : r;
   endfunction

   // A squared azimuth cosine above one acts as one.
   function automatic logic [15:0] clamp_cos(input logic [15:0] x);
      clamp_cos = (x > COS_ONE) ? COS_ONE : x;
   endfunction

endpackage

// ===== src/agme_cfg.sv =====
// Roughness registers and the products of them that the D and G paths need.
module agme_cfg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic                         csr_addr,
   input  logic [14:0]                  csr_wdata,
   output agme_pkg::agme_alpha_type     alpha
);

   logic [14:0] alpha_u_ff, alpha_v_ff;
   logic [14:0] a, b;
   logic [29:0] a2_in, b2_in, pp_in;
   logic [29:0] a2_ff, b2_ff, pp_ff;
   logic [59:0] a2b2_in, pp2_in, pm_lo_in, pm_hi_in;
   logic [59:0] a2b2_ff, pp2_ff, pm_lo_ff, pm_hi_ff;
   logic [89:0] pp3_in, pp3_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_u_ff <= agme_pkg::ALPHA_RESET;
         alpha_v_ff <= agme_pkg::ALPHA_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            agme_pkg::REG_ALPHA_U: alpha_u_ff <= csr_wdata;
            agme_pkg::REG_ALPHA_V: alpha_v_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Derived terms are registered in steps; items in flight are not held.
   assign a = agme_pkg::alpha_eff(alpha_u_ff);
   assign b = agme_pkg::alpha_eff(alpha_v_ff);
   assign a2_in = {15'd0, a} * {15'd0, a};
   assign b2_in = {15'd0, b} * {15'd0, b};
   assign pp_in = {15'd0, a} * {15'd0, b};
   assign a2b2_in = {30'd0, a2_ff} * {30'd0, b2_ff};
   assign pp2_in = {30'd0, pp_ff} * {30'd0, pp_ff};
   assign pm_lo_in = {30'd0, pp2_ff[29:0]} * {30'd0, pp_ff};
   assign pm_hi_in = {30'd0, pp2_ff[59:30]} * {30'd0, pp_ff};
   assign pp3_in = {pm_hi_ff, 30'd0} + {30'd0, pm_lo_ff};

   always_ff @(posedge clock) begin
      a2_ff <= a2_in;
      b2_ff <= b2_in;
      pp_ff <= pp_in;
      a2b2_ff <= a2b2_in;
      pp2_ff <= pp2_in;
      pm_lo_ff <= pm_lo_in;
      pm_hi_ff <= pm_hi_in;
      pp3_ff <= pp3_in;
   end

   assign alpha.a2 = a2_ff;
   assign alpha.b2 = b2_ff;
   assign alpha.a2b2 = a2b2_ff;
   assign alpha.pp3 = pp3_ff;

endmodule

// ===== src/agme_dist.sv =====
// Distribution term D: denominator products, a bit-per-layer divider and the
// scale by one over pi, with saturation.
module agme_dist (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [15:0]         n_dot_h,
   input  logic [15:0]                cos2phi_h,
   input  agme_pkg::agme_alpha_type   alpha,
   output logic [39:0]                d_value,
   output logic                       d_sat
);

   localparam int DSTEPS = agme_pkg::DIV_D_STEPS;
   localparam int LAST = agme_pkg::LAT;

   logic        pos_in;
   logic        pos_ff [1:LAST-1];
   logic [29:0] c2_1_in, c2_1_ff, c2_2_ff;
   logic [15:0] p1_in, p1_ff;
   logic [30:0] s2_2_in, s2_2_ff, s2_3_ff;
   logic [45:0] t1_2_in, t2_2_in, t1_2_ff, t2_2_ff, mix3_in, mix3_ff;
   logic [59:0] u_lo3_in, u_hi3_in, u_lo3_ff, u_hi3_ff;
   logic [89:0] x1_full;
   logic [62:0] x1_4_ff, x1_5_ff, x2_5_ff;
   logic [53:0] v_lo4_in, v_hi4_in, v_lo4_ff, v_hi4_ff;
   logic [76:0] x2_full;
   logic [63:0] bb6_in, bb6_ff;
   logic [63:0] hh7_in, hl7_in, ll7_in, hh7_ff, hl7_ff, ll7_ff;
   logic [127:0] den8_in, den8_ff, num9;
   logic         over_in;
   logic [127:0] rem_in [1:DSTEPS];
   logic [42:0]  q_in [1:DSTEPS];
   logic [127:0] rem_ff [0:DSTEPS];
   logic [127:0] den_ff [0:DSTEPS];
   logic [42:0]  q_ff [0:DSTEPS];
   logic         over_ff [0:DSTEPS+1];
   logic [61:0]  r_lo_in, r_lo_ff;
   logic [42:0]  r_hi_in, r_hi_ff;
   logic [73:0]  prod;
   logic [41:0]  v_scaled;
   logic         sat_raw;
   logic [39:0]  d_value_in, d_value_ff;
   logic         d_sat_in, d_sat_ff;

   // Cosine square and clamped azimuth term.
   assign pos_in = (n_dot_h > 16'sd0);
   assign c2_1_in = {15'd0, n_dot_h[14:0]} * {15'd0, n_dot_h[14:0]};
   assign p1_in = agme_pkg::clamp_cos(cos2phi_h);

   // Sine square and the two halves of the mixed roughness.
   assign s2_2_in = 31'h4000_0000 - {1'b0, c2_1_ff};
   assign t1_2_in = {30'd0, p1_ff} * {16'd0, alpha.b2};
   assign t2_2_in = {30'd0, agme_pkg::COS_ONE - p1_ff} * {16'd0, alpha.a2};

   // Mixed roughness, and the cosine term against a2*b2 in two halves.
   assign mix3_in = t1_2_ff + t2_2_ff;
   assign u_lo3_in = {30'd0, c2_2_ff} * {30'd0, alpha.a2b2[29:0]};
   assign u_hi3_in = {30'd0, c2_2_ff} * {30'd0, alpha.a2b2[59:30]};

   // Cosine term summed; sine term multiplied in two halves.
   assign x1_full = {u_hi3_ff, 30'd0} + {30'd0, u_lo3_ff};
   assign v_lo4_in = {23'd0, s2_3_ff} * {31'd0, mix3_ff[22:0]};
   assign v_hi4_in = {23'd0, s2_3_ff} * {31'd0, mix3_ff[45:23]};

   // Sine term summed, then the whole denominator root B.
   assign x2_full = {v_hi4_ff, 23'd0} + {23'd0, v_lo4_ff};
   assign bb6_in = {1'b0, x1_5_ff} + {1'b0, x2_5_ff};

   // B squared from three 32 by 32 partial products.
   assign hh7_in = {32'd0, bb6_ff[63:32]} * {32'd0, bb6_ff[63:32]};
   assign hl7_in = {32'd0, bb6_ff[63:32]} * {32'd0, bb6_ff[31:0]};
   assign ll7_in = {32'd0, bb6_ff[31:0]} * {32'd0, bb6_ff[31:0]};
   assign den8_in = {hh7_ff, 64'd0} + {31'd0, hl7_ff, 33'd0} + {64'd0, ll7_ff};

   // The quotient overflows when the first partial remainder already reaches B^2.
   assign num9 = {31'd0, alpha.pp3, 7'd0};
   assign over_in = (num9 >= den8_ff);

   // One quotient bit per layer.
   for (genvar k = 1; k <= DSTEPS; k++) begin : g_div
      logic [128:0] sh, diff;
      logic         ge;
      assign sh = {rem_ff[k-1], 1'b0};
      assign diff = sh - {1'b0, den_ff[k-1]};
      assign ge = (sh >= {1'b0, den_ff[k-1]});
      assign rem_in[k] = ge ? diff[127:0] : sh[127:0];
      assign q_in[k] = {q_ff[k-1][41:0], ge};
   end

   // Scale by one over pi in two partial products.
   assign r_lo_in = {31'd0, q_ff[DSTEPS][30:0]} * {31'd0, agme_pkg::INV_PI_Q32};
   assign r_hi_in = {31'd0, q_ff[DSTEPS][42:31]} * {12'd0, agme_pkg::INV_PI_Q32};

   // Final sum, saturation and the non-positive cosine case.
   assign prod = {r_hi_ff, 31'd0} + {12'd0, r_lo_ff};
   assign v_scaled = prod[73:32];
   assign sat_raw = over_ff[DSTEPS+1] | (v_scaled[41:40] != 2'b00);
   assign d_value_in = !pos_ff[LAST-1] ? '0 : (sat_raw ? '1 : v_scaled[39:0]);
   assign d_sat_in = pos_ff[LAST-1] & sat_raw;

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[1] <= pos_in;
         for (int i = 2; i <= LAST - 1; i++) pos_ff[i] <= pos_ff[i-1];
         c2_1_ff <= c2_1_in;
         p1_ff <= p1_in;
         c2_2_ff <= c2_1_ff;
         s2_2_ff <= s2_2_in;
         t1_2_ff <= t1_2_in;
         t2_2_ff <= t2_2_in;
         mix3_ff <= mix3_in;
         u_lo3_ff <= u_lo3_in;
         u_hi3_ff <= u_hi3_in;
         s2_3_ff <= s2_2_ff;
         x1_4_ff <= x1_full[89:27];
         v_lo4_ff <= v_lo4_in;
         v_hi4_ff <= v_hi4_in;
         x1_5_ff <= x1_4_ff;
         x2_5_ff <= x2_full[76:14];
         bb6_ff <= bb6_in;
         hh7_ff <= hh7_in;
         hl7_ff <= hl7_in;
         ll7_ff <= ll7_in;
         den8_ff <= den8_in;
         rem_ff[0] <= num9;
         den_ff[0] <= den8_ff;
         q_ff[0] <= '0;
         over_ff[0] <= over_in;
         for (int k = 1; k <= DSTEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_ff[k-1];
            q_ff[k] <= q_in[k];
            over_ff[k] <= over_ff[k-1];
         end
         over_ff[DSTEPS+1] <= over_ff[DSTEPS];
         r_lo_ff <= r_lo_in;
         r_hi_ff <= r_hi_in;
         d_value_ff <= d_value_in;
         d_sat_ff <= d_sat_in;
      end
   end

   assign d_value = d_value_ff;
   assign d_sat = d_sat_ff;

endmodule

// ===== src/agme_shadow.sv =====
// Smith shadowing term G: two lanes of roughness product and square root,
// then a bit-per-layer divider and a short delay to match the D path.
module agme_shadow (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [15:0]         n_dot_l,
   input  logic signed [15:0]         n_dot_v,
   input  logic signed [15:0]         h_dot_l,
   input  logic signed [15:0]         h_dot_v,
   input  logic [15:0]                cos2phi_l,
   input  logic [15:0]                cos2phi_v,
   input  logic [31:0]                tan2theta_l,
   input  logic [31:0]                tan2theta_v,
   input  agme_pkg::agme_alpha_type   alpha,
   output logic [16:0]                g_value
);

   localparam int SSTEPS = agme_pkg::SQRT_STEPS;
   localparam int GSTEPS = agme_pkg::DIV_G_STEPS;
   localparam int AGREE_LEN = agme_pkg::G_CORE_LAT - 1;
   localparam int PAD = agme_pkg::LAT - agme_pkg::G_CORE_LAT;

   logic        agree_l, agree_v, agree_in;
   logic        agree_ff [1:AGREE_LEN];
   logic [15:0] cos_lane [0:1];
   logic [31:0] tan_lane [0:1];
   logic [15:0] p_lane [0:1];
   logic [45:0] t1_in [0:1];
   logic [45:0] t2_in [0:1];
   logic [45:0] t1_ff [0:1];
   logic [45:0] t2_ff [0:1];
   logic [31:0] tn1_ff [0:1];
   logic [31:0] tn2_ff [0:1];
   logic [45:0] m2_ff [0:1];
   logic [54:0] y_lo_in [0:1];
   logic [54:0] y_hi_in [0:1];
   logic [54:0] y_lo_ff [0:1];
   logic [54:0] y_hi_ff [0:1];
   logic [77:0] y_full [0:1];
   logic [51:0] w_in [0:1];
   logic [51:0] sx_in [0:1][1:SSTEPS];
   logic [27:0] srem_in [0:1][1:SSTEPS];
   logic [25:0] sroot_in [0:1][1:SSTEPS];
   logic [51:0] sx_ff [0:1][0:SSTEPS];
   logic [27:0] srem_ff [0:1][0:SSTEPS];
   logic [25:0] sroot_ff [0:1][0:SSTEPS];
   logic [26:0] dsum_in;
   logic [26:0] grem_in [1:GSTEPS];
   logic [16:0] gq_in [1:GSTEPS];
   logic [26:0] grem_ff [0:GSTEPS];
   logic [26:0] gd_ff [0:GSTEPS];
   logic [16:0] gq_ff [0:GSTEPS];
   logic [16:0] g_core_in, g_core_ff;
   logic [16:0] gpad_ff [1:PAD];

   // Both directions must lie on the same side as the half vector.
   assign agree_l = (!n_dot_l[15] && (n_dot_l != 16'sd0) && !h_dot_l[15] && (h_dot_l != 16'sd0))
                  || (n_dot_l[15] && h_dot_l[15]);
   assign agree_v = (!n_dot_v[15] && (n_dot_v != 16'sd0) && !h_dot_v[15] && (h_dot_v != 16'sd0))
                  || (n_dot_v[15] && h_dot_v[15]);
   assign agree_in = agree_l & agree_v;

   assign cos_lane[0] = cos2phi_l;
   assign cos_lane[1] = cos2phi_v;
   assign tan_lane[0] = tan2theta_l;
   assign tan_lane[1] = tan2theta_v;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      // Mixed squared roughness for this direction, then times tan^2 in halves.
      assign p_lane[l] = agme_pkg::clamp_cos(cos_lane[l]);
      assign t1_in[l] = {30'd0, p_lane[l]} * {16'd0, alpha.a2};
      assign t2_in[l] = {30'd0, agme_pkg::COS_ONE - p_lane[l]} * {16'd0, alpha.b2};
      assign y_lo_in[l] = {32'd0, m2_ff[l][22:0]} * {23'd0, tn2_ff[l]};
      assign y_hi_in[l] = {32'd0, m2_ff[l][45:23]} * {23'd0, tn2_ff[l]};
      assign y_full[l] = {y_hi_ff[l], 23'd0} + {23'd0, y_lo_ff[l]};
      assign w_in[l] = {1'b0, y_full[l][77:27]} + 52'h0001_0000_0000;

      // Square root, one result bit per layer.
      for (genvar k = 1; k <= SSTEPS; k++) begin : g_sqrt
         logic [29:0] rt, trial, diff;
         logic        ge;
         assign rt = {srem_ff[l][k-1], sx_ff[l][k-1][51:50]};
         assign trial = {2'b00, sroot_ff[l][k-1], 2'b01};
         assign diff = rt - trial;
         assign ge = (rt >= trial);
         assign srem_in[l][k] = ge ? diff[27:0] : rt[27:0];
         assign sroot_in[l][k] = {sroot_ff[l][k-1][24:0], ge};
         assign sx_in[l][k] = {sx_ff[l][k-1][49:0], 2'b00};
      end
   end

   // G = 2^33 / (S_l + S_v): the quotient has 17 bits, so the divider starts
   // from the top 17 bits of the numerator.
   assign dsum_in = {1'b0, sroot_ff[0][SSTEPS]} + {1'b0, sroot_ff[1][SSTEPS]};

   for (genvar j = 1; j <= GSTEPS; j++) begin : g_div
      logic [27:0] sh, diff;
      logic        ge;
      assign sh = {grem_ff[j-1], 1'b0};
      assign diff = sh - {1'b0, gd_ff[j-1]};
      assign ge = (sh >= {1'b0, gd_ff[j-1]});
      assign grem_in[j] = ge ? diff[26:0] : sh[26:0];
      assign gq_in[j] = {gq_ff[j-1][15:0], ge};
   end

   assign g_core_in = agree_ff[AGREE_LEN] ? gq_ff[GSTEPS] : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         agree_ff[1] <= agree_in;
         for (int i = 2; i <= AGREE_LEN; i++) agree_ff[i] <= agree_ff[i-1];
         for (int l = 0; l < 2; l++) begin
            t1_ff[l] <= t1_in[l];
            t2_ff[l] <= t2_in[l];
            tn1_ff[l] <= tan_lane[l];
            m2_ff[l] <= t1_ff[l] + t2_ff[l];
            tn2_ff[l] <= tn1_ff[l];
            y_lo_ff[l] <= y_lo_in[l];
            y_hi_ff[l] <= y_hi_in[l];
            sx_ff[l][0] <= w_in[l];
            srem_ff[l][0] <= '0;
            sroot_ff[l][0] <= '0;
            for (int k = 1; k <= SSTEPS; k++) begin
               sx_ff[l][k] <= sx_in[l][k];
               srem_ff[l][k] <= srem_in[l][k];
               sroot_ff[l][k] <= sroot_in[l][k];
            end
         end
         grem_ff[0] <= 27'd65536;
         gd_ff[0] <= dsum_in;
         gq_ff[0] <= '0;
         for (int j = 1; j <= GSTEPS; j++) begin
            grem_ff[j] <= grem_in[j];
            gd_ff[j] <= gd_ff[j-1];
            gq_ff[j] <= gq_in[j];
         end
         g_core_ff <= g_core_in;
         gpad_ff[1] <= g_core_ff;
         for (int i = 2; i <= PAD; i++) gpad_ff[i] <= gpad_ff[i-1];
      end
   end

   assign g_value = gpad_ff[PAD];

endmodule

// ===== src/aniso_ggx_microfacet_eval.sv =====
// Channel | Direction | Fields
// req     | in        | tdata: n_dot_h, n_dot_l, n_dot_v, h_dot_l, h_dot_v, cos2phi_h,
//         |           |        cos2phi_l, cos2phi_v, tan2theta_l, tan2theta_v; tuser: op
// rsp     | out       | tdata: value; tuser: saturated
// csr     | in        | write enable, register index (0 alpha_u, 1 alpha_v), data
//
// One word is taken per cycle while the skid entry is empty; its result reaches the output
// register through the D path with its 43-layer divider, or the G path delayed to match.
// Reset clears the valid bits and sets both roughness registers to 1.0.
// The output has a register and a skid entry; the pipeline holds only while the
// skid entry is full, and no word is lost or repeated across a stall.
module aniso_ggx_microfacet_eval (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // n_dot_h, n_dot_l, n_dot_v, h_dot_l, h_dot_v, cos2phi_h, cos2phi_l, cos2phi_v,
   // tan2theta_l, tan2theta_v
   input  logic [191:0] req_tdata,
   // op
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // value
   output logic [39:0]  rsp_tdata,
   // saturated
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [14:0]  csr_wdata
);

   localparam int LAT = agme_pkg::LAT;

   agme_pkg::agme_alpha_type alpha;

   logic               en;
   logic               vld_ff [0:LAT];
   logic               op_ff [0:LAT];
   logic signed [15:0] n_dot_h_ff, n_dot_l_ff, n_dot_v_ff, h_dot_l_ff, h_dot_v_ff;
   logic [15:0]        cos2phi_h_ff, cos2phi_l_ff, cos2phi_v_ff;
   logic [31:0]        tan2theta_l_ff, tan2theta_v_ff;
   logic [39:0]        d_value;
   logic               d_sat;
   logic [16:0]        g_value;
   logic               take;
   logic [39:0]        res_value;
   logic               res_sat;
   logic               out_valid_ff, out_valid_in;
   logic [39:0]        out_value_ff, out_value_in;
   logic               out_sat_ff, out_sat_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [39:0]        skid_value_ff;
   logic               skid_sat_ff;

   agme_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .alpha     (alpha)
   );

   // The pipeline moves whenever the skid entry is free.
   assign en = !skid_valid_ff;
   assign req_tready = en;

   // Input register and the valid and op bits that travel with each word.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i <= LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff[0] <= req_tuser;
         for (int i = 1; i <= LAT; i++) op_ff[i] <= op_ff[i-1];
         n_dot_h_ff <= req_tdata[15:0];
         n_dot_l_ff <= req_tdata[31:16];
         n_dot_v_ff <= req_tdata[47:32];
         h_dot_l_ff <= req_tdata[63:48];
         h_dot_v_ff <= req_tdata[79:64];
         cos2phi_h_ff <= req_tdata[95:80];
         cos2phi_l_ff <= req_tdata[111:96];
         cos2phi_v_ff <= req_tdata[127:112];
         tan2theta_l_ff <= req_tdata[159:128];
         tan2theta_v_ff <= req_tdata[191:160];
      end
   end

   agme_dist u_dist (
      .clock     (clock),
      .en        (en),
      .n_dot_h   (n_dot_h_ff),
      .cos2phi_h (cos2phi_h_ff),
      .alpha     (alpha),
      .d_value   (d_value),
      .d_sat     (d_sat)
   );

   agme_shadow u_shadow (
      .clock       (clock),
      .en          (en),
      .n_dot_l     (n_dot_l_ff),
      .n_dot_v     (n_dot_v_ff),
      .h_dot_l     (h_dot_l_ff),
      .h_dot_v     (h_dot_v_ff),
      .cos2phi_l   (cos2phi_l_ff),
      .cos2phi_v   (cos2phi_v_ff),
      .tan2theta_l (tan2theta_l_ff),
      .tan2theta_v (tan2theta_v_ff),
      .alpha       (alpha),
      .g_value     (g_value)
   );

   // Pick the result of the requested term.
   assign res_value = op_ff[LAT] ? {23'd0, g_value} : d_value;
   assign res_sat = op_ff[LAT] ? 1'b0 : d_sat;
   assign take = en && vld_ff[LAT];

   // Output register with one skid entry behind it.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_sat_in = out_sat_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_value_in = skid_value_ff;
            out_sat_in = skid_sat_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = take;
            out_value_in = res_value;
            out_sat_in = res_sat;
         end
      end else if (take) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_sat_ff <= out_sat_in;
      if (out_valid_ff && !rsp_tready && take) begin
         skid_value_ff <= res_value;
         skid_sat_ff <= res_sat;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_value_ff;
   assign rsp_tuser = out_sat_ff;

   // The skid entry is only ever filled behind a waiting output word.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while the output register is empty");

   // A held skid word is neither dropped nor changed while the output waits.
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_tready) |=> (skid_valid_ff && $stable(skid_value_ff)))
      else $error("skid word lost or changed during a stall");

   // A saturated result carries the largest value.
   a_sat_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == {agme_pkg::VALUE_W{1'b1}}))
      else $error("saturated result without full-scale value");

endmodule

// ===== sim/aniso_ggx_microfacet_eval_chk.sv =====
// Watches the three ports of the evaluator, works out the D or G result of
// every accepted input word and compares it with the result words in order.
module aniso_ggx_microfacet_eval_chk (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [191:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [14:0]  csr_wdata,
   output int           mismatches,
   output int           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [agme_pkg::VALUE_W-1:0] value;
      logic                         saturated;
   } shade_result_type;

   localparam logic [agme_pkg::VALUE_W-1:0] VALUE_TOP = {agme_pkg::VALUE_W{1'b1}};

   // Roughness as the block holds it.
   logic [14:0] rough_u;
   logic [14:0] rough_v;

   // Results still to come, oldest first.
   shade_result_type pending_results[$];

   function automatic logic [255:0] rough_floor(input logic [14:0] r);
      return (r < 15'd2) ? 256'd2 : 256'(r);
   endfunction

   function automatic logic [255:0] cos_limit(input logic [15:0] x);
      return (x > 16'd32768) ? 256'd32768 : 256'(x);
   endfunction

   // Integer square root, bit by bit.
   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // One direction of the Smith term: floor(sqrt(1 + alpha^2 tan^2)) in Q16.
   function automatic logic [255:0] lambda_root(input logic [255:0] a2, input logic [255:0] b2,
                                                input logic [15:0] cphi,
                                                input logic [31:0] tan2);
      logic [255:0] p;
      logic [255:0] m;
      logic [255:0] w;
      p = cos_limit(cphi);
      m = p * a2 + (256'd32768 - p) * b2;
      w = (256'd1 << 32) + ((m * 256'(tan2)) >> 27);
      return 256'(root_floor(w[63:0]));
   endfunction

   function automatic shade_result_type shade_predict(input logic op, input logic [191:0] d,
                                                      input logic [14:0] ru,
                                                      input logic [14:0] rv);
      shade_result_type r;
      logic [255:0] a, b, a2, b2, c2, s2, p, mix, bb, pp, num, quo, v, sl, sv;
      int c;
      r = '0;
      a = rough_floor(ru);
      b = rough_floor(rv);
      a2 = a * a;
      b2 = b * b;
      if (!op) begin
         // Distribution term; zero for a facing-away half vector.
         c = int'($signed(d[15:0]));
         if (c > 0) begin
            c2 = 256'(c * c);
            s2 = (256'd1 << 30) - c2;
            p = cos_limit(d[95:80]);
            mix = p * b2 + (256'd32768 - p) * a2;
            bb = ((c2 * a2 * b2) >> 27) + ((s2 * mix) >> 14);
            pp = a * b;
            num = (pp * pp * pp) << 50;
            quo = num / (bb * bb);
            if (quo >= (256'd1 << 43)) begin
               r.value = VALUE_TOP;
               r.saturated = 1'b1;
            end else begin
               v = (quo * 256'd1367130551) >> 32;
               if (v > 256'(VALUE_TOP)) begin
                  r.value = VALUE_TOP;
                  r.saturated = 1'b1;
               end else begin
                  r.value = v[agme_pkg::VALUE_W-1:0];
               end
            end
         end
      end else begin
         // Shadowing term; zero when either direction changes hemisphere.
         if (((($signed(d[31:16]) > 0) && ($signed(d[63:48]) > 0)) ||
              (($signed(d[31:16]) < 0) && ($signed(d[63:48]) < 0))) &&
             ((($signed(d[47:32]) > 0) && ($signed(d[79:64]) > 0)) ||
              (($signed(d[47:32]) < 0) && ($signed(d[79:64]) < 0)))) begin
            sl = lambda_root(a2, b2, d[111:96], d[159:128]);
            sv = lambda_root(a2, b2, d[127:112], d[191:160]);
            v = (256'd1 << 33) / (sl + sv);
            r.value = v[agme_pkg::VALUE_W-1:0];
         end
      end
      return r;
   endfunction

   assign outstanding = pending_results.size();

   always @(posedge clock) begin
      shade_result_type want;
      if (reset) begin
         rough_u <= agme_pkg::ALPHA_RESET;
         rough_v <= agme_pkg::ALPHA_RESET;
         mismatches <= 0;
         pending_results.delete();
      end else begin
         // Register writes.
         if (csr_we) begin
            if (csr_addr == agme_pkg::REG_ALPHA_U) rough_u <= csr_wdata;
            else rough_v <= csr_wdata;
         end
         // Accepted input word: queue its result.
         if (req_tvalid && req_tready)
            pending_results.push_back(shade_predict(req_tuser, req_tdata, rough_u, rough_v));
         // Accepted result word: compare with the oldest expectation.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result word with none expected: value %0d saturated %0b",
                        $realtime, rsp_tdata, rsp_tuser);
               mismatches <= mismatches + 1;
            end else begin
               want = pending_results.pop_front();
               if (want.value !== rsp_tdata || want.saturated !== rsp_tuser) begin
                  $display("%0t: expected value %0d saturated %0b, got value %0d saturated %0b",
                           $realtime, want.value, want.saturated, rsp_tdata, rsp_tuser);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

// ===== sim/aniso_ggx_microfacet_eval_tb.sv =====
// Stimulus and verdict for the anisotropic GGX evaluator.
module aniso_ggx_microfacet_eval_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_OFF_CYCLES = 250;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic         csr_addr = agme_pkg::REG_ALPHA_U;
   logic [14:0]  csr_wdata = '0;

   int  mismatches;
   int  outstanding;
   int  idle_cycles = 0;
   bit  back_to_back = 1'b0;
   bit  hold_off_req = 1'b0;

   always #4 clock = ~clock;

   aniso_ggx_microfacet_eval u_top (.*);

   aniso_ggx_microfacet_eval_chk u_chk (.*);

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one word and wait until it is taken; returns at a falling edge.
   task automatic offer_word(input logic op, input logic [191:0] d);
      int gap;
      gap = back_to_back ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [191:0] pack_dots(input logic [15:0] ndh, input logic [15:0] ndl,
                                              input logic [15:0] ndv, input logic [15:0] hdl,
                                              input logic [15:0] hdv, input logic [15:0] ch,
                                              input logic [15:0] cl, input logic [15:0] cv,
                                              input logic [31:0] tl, input logic [31:0] tv);
      return {tv, tl, cv, cl, ch, hdv, hdl, ndv, ndl, ndh};
   endfunction

   function automatic logic [15:0] rand_cos();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'($urandom());
      if (r == 1) return 16'd32768;
      return 16'($urandom_range(0, 32768));
   endfunction

   function automatic logic [31:0] rand_tan();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return $urandom();
      if (r == 1) return $urandom_range(0, 65535);
      return $urandom_range(0, 32'h0010_0000);
   endfunction

   // Hemisphere pair: mostly agreeing signs, sometimes a zero or disagreement.
   task automatic rand_pair(output logic [15:0] n, output logic [15:0] h);
      int r;
      logic [15:0] x, y;
      r = $urandom_range(0, 9);
      x = 16'($urandom_range(1, 32767));
      y = 16'($urandom_range(1, 32767));
      if (r < 4) begin
         n = x; h = y;
      end else if (r < 8) begin
         n = -x; h = -y;
      end else begin
         n = 16'($urandom()); h = (r == 8) ? 16'd0 : 16'($urandom());
      end
   endtask

   task automatic send_random();
      logic [15:0] ndh, ndl, ndv, hdl, hdv;
      logic op;
      int r;
      op = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 9);
      if (r < 3) ndh = 16'($urandom());
      else if (r < 6) ndh = 16'($urandom_range(30000, 32767));
      else ndh = 16'($urandom_range(1, 32767));
      rand_pair(ndl, hdl);
      rand_pair(ndv, hdv);
      offer_word(op, pack_dots(ndh, ndl, ndv, hdl, hdv, rand_cos(), rand_cos(), rand_cos(),
                               rand_tan(), rand_tan()));
   endtask

   task automatic write_reg(input logic idx, input logic [14:0] v);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Let every result drain before touching the registers.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic directed_words();
      logic [31:0] tmax;
      tmax = 32'hFFFF_FFFF;
      // Distribution: cosine extremes, azimuth extremes and the facing-away cases.
      offer_word(1'b0, pack_dots(16'sd32767, 0, 0, 0, 0, 16'd0, 0, 0, 0, 0));
      offer_word(1'b0, pack_dots(16'sd32767, 0, 0, 0, 0, 16'd32768, 0, 0, 0, 0));
      offer_word(1'b0, pack_dots(16'sd1, 0, 0, 0, 0, 16'd16384, 0, 0, 0, 0));
      offer_word(1'b0, pack_dots(16'sd16384, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0));
      offer_word(1'b0, pack_dots(16'sd0, 1, 1, 1, 1, 16'd100, 1, 1, 1, 1));
      offer_word(1'b0, pack_dots(-16'sd1, 0, 0, 0, 0, 16'd0, 0, 0, 0, 0));
      offer_word(1'b0, pack_dots(16'h8000, 0, 0, 0, 0, 16'd32768, 0, 0, 0, 0));
      offer_word(1'b0, pack_dots(16'h8001, '1, '1, '1, '1, '1, '1, '1, tmax, tmax));
      // Shadowing: both sides, extremes of tangents and azimuths.
      offer_word(1'b1, pack_dots(0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                                 0, 16'd0, 16'd0, 32'd0, 32'd0));
      offer_word(1'b1, pack_dots(0, 16'h8000, 16'h8000, 16'h8001, 16'h8001,
                                 0, 16'hFFFF, 16'hFFFF, tmax, tmax));
      offer_word(1'b1, pack_dots(0, 16'sd1, 16'sd1, 16'sd1, 16'sd1,
                                 0, 16'd32768, 16'd0, tmax, 32'd65536));
      offer_word(1'b1, pack_dots(16'sd32767, 16'sd0, 16'sd100, 16'sd100, 16'sd100,
                                 0, 0, 0, 0, 0));
      offer_word(1'b1, pack_dots(0, 16'sd500, 16'sd100, -16'sd500, 16'sd100, 0, 0, 0, 0, 0));
      offer_word(1'b1, pack_dots(0, 16'sd500, 16'sd100, 16'sd500, -16'sd100, 0, 0, 0, 0, 0));
      offer_word(1'b1, pack_dots(0, 16'sd500, -16'sd100, 16'sd500, -16'sd100,
                                 0, 16'd20000, 16'd9000, 32'h0003_0000, 32'h0000_8000));
   endtask

   // Receiver: random stalls, and one long hold-off on request.
   initial begin
      bit held;
      held = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req && !held) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            held = 1'b1;
         end else if (pick_gap() > 0 && $urandom_range(0, 1)) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap() + 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog over cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL aniso_ggx_microfacet_eval");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [14:0] rough_u_set[6];
      logic [14:0] rough_v_set[6];
      rough_u_set = '{15'd16384, 15'd0, 15'd32767, 15'd1, 15'd32767, 15'd0};
      rough_v_set = '{15'd16384, 15'd0, 15'd32767, 15'd32767, 15'd2, 15'd0};
      rough_u_set[5] = 15'($urandom_range(2, 32767));
      rough_v_set[5] = 15'($urandom_range(2, 32767));
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed_words();
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            settle();
            write_reg(agme_pkg::REG_ALPHA_U, rough_u_set[ph]);
            write_reg(agme_pkg::REG_ALPHA_V, rough_v_set[ph]);
         end
         for (int i = 0; i < 210; i++) begin
            // Fill the pipeline against a stalled receiver once.
            if (ph == 2 && i == 20) begin
               hold_off_req = 1'b1;
               back_to_back = 1'b1;
            end
            if (ph == 2 && i == 120) back_to_back = 1'b0;
            // Pause until every result is back, then go on.
            if (ph == 3 && i == 100) begin
               req_tvalid <= 1'b0;
               while (outstanding != 0) @(negedge clock);
            end
            send_random();
         end
      end
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS aniso_ggx_microfacet_eval");
      end else begin
         $display("FAIL aniso_ggx_microfacet_eval");
      end
      $finish;
   end

endmodule

// ===== aniso_ggx_microfacet_eval.f =====
src/agme_pkg.sv
src/agme_cfg.sv
src/agme_dist.sv
src/agme_shadow.sv
src/aniso_ggx_microfacet_eval.sv
sim/aniso_ggx_microfacet_eval_chk.sv
sim/aniso_ggx_microfacet_eval_tb.sv
